@@ hdl/accumulator_machine_execute_core_defines.svh @@
// Assertion macros shared by the accumulator machine execute core.
// Needs no other file; included by the top level only.
`ifndef ACCUMULATOR_MACHINE_EXECUTE_CORE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication
`define AME_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AME_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ame_pkg.sv @@
// Types, constants and helpers for the accumulator machine execute core.
// No dependencies; imported by ame_exec, the top level and the testbench.
package ame_pkg;

   localparam int WORD_BITS = 16;
   localparam int MEM_WORDS = 8192;
   localparam int ADDR_BITS = WORD_BITS - 3;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_STORE = 3'd1,
      OP_ISZ   = 3'd2,
      OP_JUMP  = 3'd3,
      OP_HALT  = 3'd4,
      OP_BZAC  = 3'd5,
      OP_ADD   = 3'd6,
      OP_SWAP  = 3'd7
   } opcode_type;

   typedef struct packed {
      logic                 command;
      logic [WORD_BITS-1:0] instruction;
      logic [ADDR_BITS-1:0] pc_in;
      logic [ADDR_BITS-1:0] load_address;
      logic [WORD_BITS-1:0] load_data;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] next_pc;
      logic [WORD_BITS-1:0] accumulator_value;
      logic                 halted;
      logic [2:0]           opcode_done;
   } rsp_item_type;

   typedef struct packed {
      logic                 en;
      logic [MEM_AW-1:0]    addr;
      logic [WORD_BITS-1:0] data;
   } ame_wr_type;

   typedef struct packed {
      logic s1_valid;
      logic halted;
   } ame_status_type;

   // word address to memory index (modulo MEM_WORDS)
   function automatic logic [MEM_AW-1:0] mem_idx(input logic [ADDR_BITS-1:0] addr);
      return addr[MEM_AW-1:0];
   endfunction

endpackage

@@ hdl/ame_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ame_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ame_exec.sv @@
// Execute stage: holds the item whose memory word is being read, the
// accumulator and halt flag, forwards the last write, computes the result.
// Depends on ame_pkg.
module ame_exec
   import ame_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  req_item_type   req_item,
   input  logic [WORD_BITS-1:0] rd_data,
   input  logic           advance,
   output ame_wr_type     wr,
   output ame_status_type status,
   output rsp_item_type   result
);

   logic                 s1_valid_ff, s1_valid_in;
   req_item_type         s1_item_ff;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 halt_ff, halt_in;
   logic                 fwd_valid_ff;
   logic [MEM_AW-1:0]    fwd_addr_ff;
   logic [WORD_BITS-1:0] fwd_data_ff;

   logic [MEM_AW-1:0]    idx;
   logic [WORD_BITS-1:0] mem_word;
   logic [WORD_BITS-1:0] inc_word;
   logic [ADDR_BITS-1:0] pc_next;
   logic [2:0]           opc;
   logic                 do_write;
   logic [MEM_AW-1:0]    w_addr;
   logic [WORD_BITS-1:0] w_data;
   opcode_type           op;

   assign idx      = mem_idx(s1_item_ff.instruction[ADDR_BITS-1:0]);
   // write landing on the same edge as the read is not in rd_data yet
   assign mem_word = (fwd_valid_ff && fwd_addr_ff == idx) ? fwd_data_ff : rd_data;
   assign inc_word = mem_word + WORD_BITS'(1);
   assign op       = opcode_type'(s1_item_ff.instruction[WORD_BITS-1 -: 3]);

   always_comb begin
      acc_in   = acc_ff;
      halt_in  = halt_ff;
      pc_next  = s1_item_ff.pc_in;
      opc      = 3'd0;
      do_write = 1'b0;
      w_addr   = idx;
      w_data   = acc_ff;
      if (s1_item_ff.command) begin
         do_write = 1'b1;
         w_addr   = mem_idx(s1_item_ff.load_address);
         w_data   = s1_item_ff.load_data;
      end else if (!halt_ff) begin
         opc = op;
         case (op)
            OP_LOAD: begin
               acc_in = mem_word;
            end
            OP_STORE: begin
               do_write = 1'b1;
            end
            OP_ISZ: begin
               do_write = 1'b1;
               w_data   = inc_word;
               if (inc_word == '0) begin
                  pc_next = s1_item_ff.pc_in + ADDR_BITS'(1);
               end
            end
            OP_JUMP: begin
               pc_next = s1_item_ff.instruction[ADDR_BITS-1:0];
            end
            OP_HALT: begin
               halt_in = 1'b1;
            end
            OP_BZAC: begin
               if (acc_ff == '0) begin
                  pc_next = s1_item_ff.instruction[ADDR_BITS-1:0];
               end
            end
            OP_ADD: begin
               acc_in = acc_ff + mem_word;
            end
            OP_SWAP: begin
               do_write = 1'b1;
               acc_in   = mem_word;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   assign wr.en   = s1_valid_ff && advance && do_write;
   assign wr.addr = w_addr;
   assign wr.data = w_data;

   assign s1_valid_in = take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         halt_ff      <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_valid_ff && advance) begin
            acc_ff  <= acc_in;
            halt_ff <= halt_in;
         end
         if (wr.en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff <= req_item;
      end
      if (wr.en) begin
         fwd_addr_ff <= wr.addr;
         fwd_data_ff <= wr.data;
      end
   end

   assign status.s1_valid = s1_valid_ff;
   assign status.halted   = halt_ff;

   assign result.next_pc           = pc_next;
   assign result.accumulator_value = acc_in;
   assign result.halted            = halt_in;
   assign result.opcode_done       = opc;

endmodule

@@ hdl/accumulator_machine_execute_core.sv @@
// Execute stage of an eight-instruction accumulator machine. An item either
// loads a word into the 8192-word data memory or executes one instruction
// with its already-incremented program counter; each item gives one result
// with the next program counter, the accumulator, the halt flag and the
// executed opcode. Items are taken one per clock when the result side keeps
// up; a result is offered from the output register: the data memory read
// is registered when the item is accepted, and modify, write-back and the
// output register load follow together once the output register is free.
// A write and a read of the same word on consecutive items are bypassed,
// so no bubbles are inserted. The data memory is not cleared after reset:
// a word read before it was ever written is undefined.
// Depends on ame_pkg, ame_ram, ame_exec and the defines header.
`include "accumulator_machine_execute_core_defines.svh"

module accumulator_machine_execute_core
   import ame_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic                 take;
   logic                 out_free;
   logic [WORD_BITS-1:0] rd_data;
   ame_wr_type           wr;
   ame_status_type       status;
   rsp_item_type         result;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_item_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = status.s1_valid && !out_free;
   assign take      = req_valid && !req_stall;

   ame_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MEM_WORDS)
   ) u_data_mem (
      .clock  (clock),
      .wr_en  (wr.en),
      .wr_addr(wr.addr),
      .wr_data(wr.data),
      .rd_en  (take),
      .rd_addr(mem_idx(req_item.instruction[ADDR_BITS-1:0])),
      .rd_data(rd_data)
   );

   ame_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .req_item(req_item),
      .rd_data (rd_data),
      .advance (out_free),
      .wr      (wr),
      .status  (status),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= status.s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && status.s1_valid) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `AME_ASSERT_NEXT(a_take_fills_stage, clock, reset, take, status.s1_valid, "item lost")
   `AME_ASSERT_NEXT(a_halt_sticky, clock, reset, status.halted, status.halted, "halt cleared")
   `AME_ASSERT_NOW(a_write_needs_item, clock, reset, wr.en, status.s1_valid && out_free, "stray write")

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for accumulator_machine_execute_core: directed and random
// load/instruction items under several idle/stall mixes, checked by a scoreboard class.
// Depends on ame_pkg and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ame_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 220;
   localparam int HALT_ITEMS   = 30;
   localparam int DRAIN_CYCLES = 8;
   localparam int SHOWN_ERRORS = 10;

   class exec_board;
      logic [WORD_BITS-1:0] acc;
      bit                   halt_flag;
      logic [WORD_BITS-1:0] mem [MEM_WORDS];
      bit                   written [MEM_WORDS];
      int                   written_addrs [$];
      rsp_item_type         rsp_due [$];
      int                   errors;
      int                   checked;
      int                   loads;
      int                   op_hits [8];

      function new();
         acc       = '0;
         halt_flag = 1'b0;
         errors    = 0;
         checked   = 0;
         loads     = 0;
         foreach (op_hits[i]) op_hits[i] = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void mark_written(int idx);
         if (!written[idx]) begin
            written[idx] = 1'b1;
            written_addrs.push_back(idx);
         end
      endfunction

      function logic [ADDR_BITS-1:0] pick_written();
         return ADDR_BITS'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
      endfunction

      // advance the machine by one accepted item and queue the result it owes
      function void apply_req(req_item_type r);
         rsp_item_type         e;
         opcode_type           op;
         logic [ADDR_BITS-1:0] a;
         logic [WORD_BITS-1:0] w;
         int                   idx;
         e.next_pc     = r.pc_in;
         e.opcode_done = OP_LOAD;  // zero when nothing executes
         if (r.command) begin
            idx      = int'(r.load_address) % MEM_WORDS;
            mem[idx] = r.load_data;
            mark_written(idx);
            loads++;
         end else if (!halt_flag) begin
            op  = opcode_type'(r.instruction[WORD_BITS-1 -: 3]);
            a   = r.instruction[ADDR_BITS-1:0];
            idx = int'(a) % MEM_WORDS;
            e.opcode_done = op;
            op_hits[op]++;
            case (op)
               OP_LOAD:  acc = mem[idx];
               OP_STORE: begin
                  mem[idx] = acc;
                  mark_written(idx);
               end
               OP_ISZ: begin
                  w        = mem[idx] + 1'b1;
                  mem[idx] = w;
                  if (w == '0) e.next_pc = r.pc_in + 1'b1;
               end
               OP_JUMP:  e.next_pc = a;
               OP_HALT:  halt_flag = 1'b1;
               OP_BZAC:  if (acc == '0) e.next_pc = a;
               OP_ADD:   acc = acc + mem[idx];
               OP_SWAP: begin
                  w        = mem[idx];
                  mem[idx] = acc;
                  acc      = w;
               end
               default:  acc = acc;
            endcase
         end
         e.accumulator_value = acc;
         e.halted            = halt_flag;
         rsp_due.push_back(e);
      endfunction

      function void check_rsp(rsp_item_type act);
         rsp_item_type e;
         if (rsp_due.size() == 0) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
               $display("ERROR: result with none due: pc %0d acc %h halted %b op %0d",
                        act.next_pc, act.accumulator_value, act.halted, act.opcode_done);
            return;
         end
         e = rsp_due.pop_front();
         checked++;
         if (act.next_pc !== e.next_pc || act.accumulator_value !== e.accumulator_value ||
             act.halted !== e.halted || act.opcode_done !== e.opcode_done) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
               $display("ERROR: result %0d: exp pc %0d acc %h halted %b op %0d, %s%0d %h %b %0d",
                        checked, e.next_pc, e.accumulator_value, e.halted, e.opcode_done,
                        "got ", act.next_pc, act.accumulator_value, act.halted,
                        act.opcode_done);
         end
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          sent          = 0;
   int unsigned cycle_count   = 0;
   exec_board   board         = new();

   accumulator_machine_execute_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("accumulator_machine_execute_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_rsp(rsp_item);
   end

   function automatic req_item_type load_req(logic [ADDR_BITS-1:0] a, logic [WORD_BITS-1:0] d);
      req_item_type r;
      r.command      = 1'b1;
      r.instruction  = 16'($urandom);
      r.pc_in        = ADDR_BITS'($urandom);
      r.load_address = a;
      r.load_data    = d;
      return r;
   endfunction

   function automatic req_item_type exec_req(opcode_type op, logic [ADDR_BITS-1:0] a,
                                             logic [ADDR_BITS-1:0] pc);
      req_item_type r;
      r.command      = 1'b0;
      r.instruction  = {op, a};
      r.pc_in        = pc;
      r.load_address = ADDR_BITS'($urandom);
      r.load_data    = 16'($urandom);
      return r;
   endfunction

   function automatic req_item_type random_req(bit allow_halt);
      req_item_type         r;
      opcode_type           op;
      logic [ADDR_BITS-1:0] a;
      logic [WORD_BITS-1:0] d;
      a = $urandom_range(1) ? ADDR_BITS'($urandom_range(31)) : ADDR_BITS'($urandom);
      case ($urandom_range(5))
         0:       d = '0;
         1:       d = '1;
         2:       d = 16'hfffe;
         default: d = 16'($urandom);
      endcase
      r = load_req(a, d);
      if ($urandom_range(99) >= 22) begin
         do op = opcode_type'($urandom_range(7)); while (op == OP_HALT && !allow_halt);
         // never read a word that was never written
         if (!board.halt_flag && op inside {OP_LOAD, OP_ISZ, OP_ADD, OP_SWAP} &&
             !board.written[int'(a) % MEM_WORDS])
            a = board.pick_written();
         r = exec_req(op, a, ($urandom_range(15) == 0) ? '1 : ADDR_BITS'($urandom));
      end
      return r;
   endfunction

   task automatic send_req(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.apply_req(it);
      sent++;
   endtask

   task automatic run_phase(int n, int idle, int stall, bit allow_halt);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) send_req(random_req(allow_halt));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_req(load_req(13'd0, 16'h0000));
      send_req(load_req(13'h1fff, 16'hffff));
      send_req(load_req(13'd1, 16'hffff));
      send_req(load_req(13'd2, 16'h0001));
      send_req(exec_req(OP_LOAD, 13'd0, 13'd0));
      send_req(exec_req(OP_BZAC, 13'h1fff, 13'd5));     // taken, acc zero
      send_req(exec_req(OP_LOAD, 13'h1fff, 13'h1fff));
      send_req(exec_req(OP_BZAC, 13'd0, 13'd9));        // not taken
      send_req(exec_req(OP_ADD, 13'd2, 13'd10));        // wraps to zero
      send_req(exec_req(OP_ISZ, 13'd1, 13'h1fff));      // skip, pc wraps
      send_req(exec_req(OP_ISZ, 13'd1, 13'd12));        // no skip
      send_req(exec_req(OP_STORE, 13'd3, 13'd13));
      send_req(exec_req(OP_LOAD, 13'h1fff, 13'd14));
      send_req(exec_req(OP_STORE, 13'h1ffe, 13'd15));
      send_req(exec_req(OP_ADD, 13'd1, 13'd16));
      send_req(exec_req(OP_SWAP, 13'd2, 13'd17));
      send_req(exec_req(OP_SWAP, 13'd2, 13'd18));
      send_req(exec_req(OP_JUMP, 13'h1fff, 13'd0));
      send_req(exec_req(OP_JUMP, 13'd0, 13'h1fff));
      send_req(load_req(13'h1555, 16'haaaa));
      send_req(load_req(13'h0aaa, 16'h5555));

      run_phase(PHASE_ITEMS, 0, 0, 1'b0);
      run_phase(PHASE_ITEMS, 68, 0, 1'b0);
      run_phase(PHASE_ITEMS, 0, 68, 1'b0);
      run_phase(PHASE_ITEMS, 12, 12, 1'b0);

      // halt is sticky: instructions after it must leave state alone; loads still write
      send_req(exec_req(OP_HALT, 13'h1fff, 13'd100));
      run_phase(HALT_ITEMS, 12, 12, 1'b1);
      send_req(exec_req(OP_HALT, 13'd0, 13'd0));
      req_valid <= 1'b0;

      while (board.rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d loads) through four idle/stall mixes plus a halted tail;",
               sent, board.loads);
      $display("executed LOAD %0d STORE %0d ISZ %0d JUMP %0d HALT %0d BZAC %0d ADD %0d %s%0d",
               board.op_hits[OP_LOAD], board.op_hits[OP_STORE], board.op_hits[OP_ISZ],
               board.op_hits[OP_JUMP], board.op_hits[OP_HALT], board.op_hits[OP_BZAC],
               board.op_hits[OP_ADD], "SWAP ", board.op_hits[OP_SWAP]);
      if (board.errors == 0 && board.rsp_due.size() == 0) begin
         $display("accumulator_machine_execute_core: match");
      end else begin
         $display("accumulator_machine_execute_core: mismatch");
      end
      $finish;
   end
endmodule
